>>> hdl/cu_pkg.sv
package cu_pkg;

	localparam int RANK_W    = 22;
	localparam int IDX_W     = 6;
	localparam int SET_W     = 6;
	localparam int PICK_W    = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 6;
	localparam int BIN_W     = 23;
	localparam int BIN_SAT   = 2 ** 22;
	localparam int ROW_LEN   = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PICK_COUNT = 2'd1;

	typedef struct packed {
		logic busy;
		logic done;
		logic err;
	} cu_stat_t;

	// C(v,p) built by Pascal rows, clipped at BIN_SAT
	function automatic logic [BIN_W-1:0] binom_sat(input int v, input int p);
		int row [ROW_LEN];
		int sum;
		for (int j = 0; j < ROW_LEN; j++) begin
			row[j] = 0;
		end
		row[0] = 1;
		for (int i = 1; i <= v; i++) begin
			for (int j = ROW_LEN - 1; j >= 1; j--) begin
				sum = row[j] + row[j-1];
				row[j] = (sum > BIN_SAT) ? BIN_SAT : sum;
			end
		end
		return BIN_W'(row[p]);
	endfunction

endpackage

>>> hdl/cu_binom_rom.sv
module cu_binom_rom import cu_pkg::*; #(
	parameter int P_W = 3,
	parameter int V_W = 6
) (
	input  logic               clk,
	input  logic [P_W+V_W-1:0] addr,
	output logic [BIN_W-1:0]   rd_data
);

	localparam int DEPTH = 2 ** (P_W + V_W);

	logic [BIN_W-1:0] rom [DEPTH];
	logic [BIN_W-1:0] rd_data_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_rom
		assign rom[i] = binom_sat(i % (2 ** V_W), i >> V_W);
	end

	always_ff @(posedge clk) begin
		rd_data_q <= rom[addr];
	end

	assign rd_data = rd_data_q;

endmodule

>>> hdl/cu_search.sv
module cu_search import cu_pkg::*; #(
	parameter int MAX_SET  = 52,
	parameter int MAX_PICK = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RANK_W-1:0] rank,
	input  logic [SET_W-1:0]  set_size,
	input  logic [PICK_W-1:0] pick_count,
	input  logic              take,
	output cu_stat_t          stat,
	output logic [IDX_W-1:0]  res_idx [MAX_PICK]
);

	localparam int V_W  = $clog2(MAX_SET + 1);
	localparam int P_W  = $clog2(MAX_PICK + 1);
	localparam int SL_W = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;

	localparam logic [SET_W:0]  MAX_SET_C  = (SET_W + 1)'(MAX_SET);
	localparam logic [PICK_W:0] MAX_PICK_C = (PICK_W + 1)'(MAX_PICK);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_CHECK  = 4'b0010,
		ST_SEARCH = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t state_q, state_d;

	logic [V_W-1:0]    n_q;
	logic [P_W-1:0]    k_q;
	logic [P_W-1:0]    p_q;
	logic [V_W-1:0]    lo_q, hi_q, top_q;
	logic [RANK_W-1:0] rem_q;
	logic [BIN_W-1:0]  best_q;
	logic [SL_W-1:0]   slot_q;
	logic              err_q;
	logic [IDX_W-1:0]  idx_q [MAX_PICK];

	logic              cfg_bad;
	logic              chk_err;
	logic              last;
	logic              probe_ok;
	logic [V_W:0]      mid_sum;
	logic [V_W-1:0]    mid_cur;
	logic [P_W-1:0]    nxt_p;
	logic [V_W-1:0]    nxt_lo, nxt_hi;
	logic [V_W:0]      nxt_sum;
	logic [BIN_W-1:0]  rd_data;

	cu_binom_rom #(
		.P_W(P_W),
		.V_W(V_W)
	) u_rom (
		.clk    (clk),
		.addr   ({nxt_p, nxt_sum[V_W:1]}),
		.rd_data(rd_data)
	);

	assign cfg_bad = (pick_count == '0) || ({1'b0, pick_count} > MAX_PICK_C) ||
		({1'b0, set_size} > MAX_SET_C) || (set_size < {3'b000, pick_count});

	assign chk_err  = err_q || (rem_q == '0) || ({1'b0, rem_q} > rd_data);
	assign last     = (lo_q == hi_q);
	assign probe_ok = (rd_data <= {1'b0, rem_q});
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q} + (V_W + 1)'(1);
	assign mid_cur  = mid_sum[V_W:1];
	assign nxt_sum  = {1'b0, nxt_lo} + {1'b0, nxt_hi} + (V_W + 1)'(1);

	always_comb begin
		nxt_p  = p_q;
		nxt_lo = lo_q;
		nxt_hi = hi_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cfg_bad) begin
					nxt_p  = '0;
					nxt_lo = '0;
					nxt_hi = '0;
				end else begin
					nxt_p  = P_W'(pick_count);
					nxt_lo = V_W'(set_size);
					nxt_hi = V_W'(set_size);
				end
			end
			ST_CHECK: begin
				nxt_p  = k_q;
				nxt_lo = V_W'(k_q) - V_W'(1);
				nxt_hi = n_q - V_W'(1);
			end
			ST_SEARCH: begin
				if (last) begin
					nxt_p  = p_q - P_W'(1);
					nxt_lo = V_W'(p_q) - V_W'(2);
					nxt_hi = top_q - V_W'(1);
				end else if (probe_ok) begin
					nxt_lo = mid_cur;
				end else begin
					nxt_hi = mid_cur - V_W'(1);
				end
			end
			ST_FINISH: begin
				nxt_p  = '0;
				nxt_lo = '0;
				nxt_hi = '0;
			end
			default: begin
				nxt_p  = '0;
				nxt_lo = '0;
				nxt_hi = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (start) state_d = ST_CHECK;
			ST_CHECK:  state_d = chk_err ? ST_FINISH : ST_SEARCH;
			ST_SEARCH: if (last && (p_q == P_W'(1))) state_d = ST_FINISH;
			ST_FINISH: if (take) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					n_q    <= V_W'(set_size);
					k_q    <= P_W'(pick_count);
					rem_q  <= rank;
					err_q  <= cfg_bad;
					slot_q <= '0;
					for (int j = 0; j < MAX_PICK; j++) begin
						idx_q[j] <= '0;
					end
				end
			end
			ST_CHECK: begin
				err_q  <= chk_err;
				rem_q  <= rem_q - RANK_W'(1);
				p_q    <= nxt_p;
				lo_q   <= nxt_lo;
				hi_q   <= nxt_hi;
				top_q  <= nxt_hi;
				best_q <= '0;
			end
			ST_SEARCH: begin
				p_q  <= nxt_p;
				lo_q <= nxt_lo;
				hi_q <= nxt_hi;
				if (last) begin
					idx_q[slot_q] <= IDX_W'(n_q - V_W'(1) - lo_q);
					rem_q         <= rem_q - best_q[RANK_W-1:0];
					slot_q        <= slot_q + SL_W'(1);
					top_q         <= nxt_hi;
					best_q        <= '0;
				end else if (probe_ok) begin
					best_q <= rd_data;
				end
			end
			ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_FINISH);
	assign stat.err  = err_q;

	for (genvar j = 0; j < MAX_PICK; j++) begin : g_res
		assign res_idx[j] = idx_q[j];
	end

endmodule

>>> hdl/combination_unrank.sv
// Sequence: a rejected rank or setting goes from the check state straight to finish; otherwise
// a binary search runs for each position before finish, and out_valid follows the hand-off.
// Throughput: one item at a time; in_stall stays high until the result is handed to the output
// register; each probe is one read of the registered binomial ROM.
// A new item may transfer while the previous result waits in the output register.
// Reset: arst_n asynchronous active low; clears control, set_size to 52, pick_count to 5.
module combination_unrank import cu_pkg::*; #(
	parameter int MAX_SET  = 52,
	parameter int MAX_PICK = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [RANK_W-1:0]    rank,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [IDX_W-1:0]     first_index,
	output logic [IDX_W-1:0]     second_index,
	output logic [IDX_W-1:0]     third_index,
	output logic [IDX_W-1:0]     fourth_index,
	output logic [IDX_W-1:0]     fifth_index,
	output logic                 rank_error
);

	localparam int OUT_N = 5;

	logic [SET_W-1:0]  set_size_q;
	logic [PICK_W-1:0] pick_count_q;
	logic              out_valid_q;
	logic              out_err_q;
	logic [IDX_W-1:0]  out_idx_q [OUT_N];
	logic [IDX_W-1:0]  res_idx [MAX_PICK];
	logic [IDX_W-1:0]  res_full [OUT_N];
	cu_stat_t          stat;
	logic              start;
	logic              take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size_q   <= SET_W'(52);
			pick_count_q <= PICK_W'(5);
		end else if (cfg_we) begin
			if (cfg_index == REG_SET_SIZE) begin
				set_size_q <= cfg_wdata[SET_W-1:0];
			end else if (cfg_index == REG_PICK_COUNT) begin
				pick_count_q <= cfg_wdata[PICK_W-1:0];
			end
		end
	end

	assign in_stall = stat.busy;
	assign start    = in_valid && !stat.busy;
	assign take     = stat.done && (!out_valid_q || !out_stall);

	cu_search #(
		.MAX_SET (MAX_SET),
		.MAX_PICK(MAX_PICK)
	) u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.rank      (rank),
		.set_size  (set_size_q),
		.pick_count(pick_count_q),
		.take      (take),
		.stat      (stat),
		.res_idx   (res_idx)
	);

	for (genvar j = 0; j < OUT_N; j++) begin : g_full
		if (j < MAX_PICK) begin : g_used
			assign res_full[j] = res_idx[j];
		end else begin : g_zero
			assign res_full[j] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_err_q <= stat.err;
			for (int j = 0; j < OUT_N; j++) begin
				out_idx_q[j] <= res_full[j];
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign rank_error   = out_err_q;
	assign first_index  = out_idx_q[0];
	assign second_index = out_idx_q[1];
	assign third_index  = out_idx_q[2];
	assign fourth_index = out_idx_q[3];
	assign fifth_index  = out_idx_q[4];

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after transfer");

	a_error_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rank_error |-> (first_index == '0) && (second_index == '0) &&
			(third_index == '0) && (fourth_index == '0) && (fifth_index == '0))
		else $error("nonzero index with rank error");

	a_index_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rank_error && (second_index != '0) |-> first_index < second_index)
		else $error("indexes not strictly increasing");

endmodule

>>> bench/unrank_checker.sv
`timescale 1ns / 100ps

module unrank_checker import cu_pkg::*; #(
	parameter int MAX_SET  = 52,
	parameter int MAX_PICK = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [RANK_W-1:0]    rank,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [IDX_W-1:0]     first_index,
	input  logic [IDX_W-1:0]     second_index,
	input  logic [IDX_W-1:0]     third_index,
	input  logic [IDX_W-1:0]     fourth_index,
	input  logic [IDX_W-1:0]     fifth_index,
	input  logic                 rank_error,
	output int                   errors,
	output int                   pending
);

	typedef struct packed {
		logic [IDX_W-1:0] first_idx;
		logic [IDX_W-1:0] second_idx;
		logic [IDX_W-1:0] third_idx;
		logic [IDX_W-1:0] fourth_idx;
		logic [IDX_W-1:0] fifth_idx;
		logic             bad;
	} combo_t;

	combo_t              due_combos [$];
	combo_t              want;
	combo_t              got;
	logic [SET_W-1:0]    set_size_q   = 6'd52;
	logic [PICK_W-1:0]   pick_count_q = 3'd5;

	function automatic longint unsigned choose(input int v, input int p);
		longint unsigned c;
		c = 1;
		if (v < p)
			return 0;
		for (int j = 1; j <= p; j++)
			c = c * longint'(v - p + j) / longint'(j);
		return c;
	endfunction

	function automatic combo_t unrank(input logic [RANK_W-1:0] rk, input int n, input int k);
		longint unsigned rest;
		int              v;
		logic [IDX_W-1:0] pos [5];
		combo_t          res;
		res = '0;
		for (int j = 0; j < 5; j++)
			pos[j] = '0;
		if (k == 0 || k > MAX_PICK || n > MAX_SET || n < k || rk == 0 || rk > choose(n, k)) begin
			res.bad = 1'b1;
			return res;
		end
		rest = rk - 1;
		for (int p = k; p >= 1; p--) begin
			v = n - k + p - 1;
			while (v > p - 1 && choose(v, p) > rest)
				v--;
			if (k - p < 5)
				pos[k-p] = IDX_W'(n - 1 - v);
			rest -= choose(v, p);
		end
		res.first_idx  = pos[0];
		res.second_idx = pos[1];
		res.third_idx  = pos[2];
		res.fourth_idx = pos[3];
		res.fifth_idx  = pos[4];
		return res;
	endfunction

	task automatic check_field(input string name, input logic [IDX_W-1:0] exp_v,
		input logic [IDX_W-1:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size_q   = 6'd52;
			pick_count_q = 3'd5;
			pending      = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SET_SIZE:   set_size_q   = cfg_wdata[SET_W-1:0];
					REG_PICK_COUNT: pick_count_q = cfg_wdata[PICK_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				due_combos.push_back(unrank(rank, int'(set_size_q), int'(pick_count_q)));
			if (out_valid && !out_stall) begin
				got = '{first_index, second_index, third_index, fourth_index, fifth_index,
					rank_error};
				if (due_combos.size() == 0) begin
					errors++;
					$display("%0t: extra result, expected none, actual %0d %0d %0d %0d %0d err %0d",
						$time, first_index, second_index, third_index, fourth_index,
						fifth_index, rank_error);
				end else begin
					want = due_combos.pop_front();
					check_field("first_index", want.first_idx, got.first_idx);
					check_field("second_index", want.second_idx, got.second_idx);
					check_field("third_index", want.third_idx, got.third_idx);
					check_field("fourth_index", want.fourth_idx, got.fourth_idx);
					check_field("fifth_index", want.fifth_idx, got.fifth_idx);
					check_field("rank_error", IDX_W'(want.bad), IDX_W'(got.bad));
				end
			end
			pending = due_combos.size();
		end
	end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top import cu_pkg::*; ();

	localparam int MAX_SET    = 52;
	localparam int MAX_PICK   = 5;
	localparam int RAND_ITEMS = 1150;
	localparam int RANK_TOP   = 2 ** RANK_W - 1;
	localparam int DRAIN_WAIT = 45;
	localparam int HOLD_LEN   = 400;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_TOP = 2'd3;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [RANK_W-1:0]    rank      = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [IDX_W-1:0]     first_index;
	logic [IDX_W-1:0]     second_index;
	logic [IDX_W-1:0]     third_index;
	logic [IDX_W-1:0]     fourth_index;
	logic [IDX_W-1:0]     fifth_index;
	logic                 rank_error;
	int                   mismatches;
	int                   outstanding;

	bit in_quiet  = 1'b0;
	bit out_quiet = 1'b0;
	bit hold_go   = 1'b0;
	int cur_n     = 52;
	int cur_k     = 5;
	int sent      = 0;
	int bad_sent  = 0;
	int settings  = 0;

	always #5 clk = ~clk;

	combination_unrank #(
		.MAX_SET  (MAX_SET),
		.MAX_PICK (MAX_PICK)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rank         (rank),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.first_index  (first_index),
		.second_index (second_index),
		.third_index  (third_index),
		.fourth_index (fourth_index),
		.fifth_index  (fifth_index),
		.rank_error   (rank_error)
	);

	unrank_checker #(
		.MAX_SET  (MAX_SET),
		.MAX_PICK (MAX_PICK)
	) CHK (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rank         (rank),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.first_index  (first_index),
		.second_index (second_index),
		.third_index  (third_index),
		.fourth_index (fourth_index),
		.fifth_index  (fifth_index),
		.rank_error   (rank_error),
		.errors       (mismatches),
		.pending      (outstanding)
	);

	function automatic int combos_of(input int n, input int k);
		longint c;
		c = 1;
		if (k == 0 || k > MAX_PICK || n > MAX_SET || n < k)
			return 0;
		for (int j = 1; j <= k; j++)
			c = c * (n - k + j) / j;
		return int'(c);
	endfunction

	function automatic logic [RANK_W-1:0] pick_rank();
		int total;
		int roll;
		total = combos_of(cur_n, cur_k);
		roll  = $urandom_range(99);
		if (total == 0 || roll < 6)
			return RANK_W'($urandom);
		if (roll < 10)
			return '0;
		if (roll < 15)
			return RANK_W'(total + 1 + $urandom_range(RANK_TOP - total - 1));
		if (roll < 18)
			return RANK_W'(total);
		if (roll < 20)
			return RANK_W'(1);
		return RANK_W'(1 + $urandom_range(total - 1));
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_config(input int n, input int k);
		write_reg(REG_SET_SIZE, CFG_W'(n));
		write_reg(REG_PICK_COUNT, CFG_W'((k & 7) | ($urandom_range(7) << PICK_W)));
		cur_n = n & 63;
		cur_k = k & 7;
		settings++;
	endtask

	task automatic send_rank(input logic [RANK_W-1:0] value);
		int total;
		total = combos_of(cur_n, cur_k);
		while (!in_quiet && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rank     <= value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
		if (value == 0 || value > total)
			bad_sent++;
	endtask

	// hold until every expected result is back, then let the block settle
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_go) begin
				hold_go   = 1'b0;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !out_quiet && ($urandom_range(99) < 26);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int rand_sent;
		int phase;
		int sel;
		int n;
		int k;
		int batch;
		rand_sent = 0;
		phase     = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_rank(RANK_W'(1));
		send_rank(RANK_W'(2598960));
		send_rank(RANK_W'(2598961));
		send_rank('0);
		send_rank(RANK_W'(RANK_TOP));
		send_rank(RANK_W'(1234567));
		drain_results();
		set_config(5, 5);
		send_rank(RANK_W'(1));
		send_rank(RANK_W'(2));
		drain_results();
		set_config(52, 1);
		send_rank(RANK_W'(1));
		send_rank(RANK_W'(52));
		send_rank(RANK_W'(53));
		drain_results();
		set_config(5, 1);
		send_rank(RANK_W'(5));
		drain_results();
		set_config(5, 2);
		send_rank(RANK_W'(10));
		drain_results();
		write_reg(REG_SPARE, 6'h3F);
		write_reg(REG_SPARE_TOP, 6'h00);
		send_rank(RANK_W'(3));
		drain_results();
		set_config(52, 0);
		send_rank(RANK_W'(1));
		drain_results();
		set_config(52, 6);
		send_rank(RANK_W'(1));
		drain_results();
		set_config(52, 7);
		send_rank(RANK_W'(1));
		drain_results();
		set_config(53, 5);
		send_rank(RANK_W'(1));
		drain_results();
		set_config(63, 5);
		send_rank(RANK_W'(1));
		drain_results();
		set_config(3, 5);
		send_rank(RANK_W'(1));
		drain_results();
		set_config(0, 1);
		send_rank(RANK_W'(1));

		while (rand_sent < RAND_ITEMS) begin
			drain_results();
			phase++;
			sel   = $urandom_range(99);
			batch = 30 + $urandom_range(50);
			if (sel < 8) begin
				n = $urandom_range(63);
				k = $urandom_range(7);
			end else if (sel < 20) begin
				n = ($urandom_range(1) == 1) ? 52 : 5;
				k = ($urandom_range(1) == 1) ? 5 : 1;
			end else begin
				k = $urandom_range(MAX_PICK, 1);
				n = $urandom_range(MAX_SET, 5);
			end
			if (phase == 3) begin
				in_quiet  = 1'b1;
				out_quiet = 1'b1;
				batch     = 150;
			end
			if (phase == 5) begin
				n        = 52;
				k        = 5;
				in_quiet = 1'b1;
				batch    = 25;
			end
			set_config(n, k);
			if (phase == 5)
				hold_go = 1'b1;
			repeat (batch) begin
				send_rank(pick_rank());
				rand_sent++;
			end
			in_quiet  = 1'b0;
			out_quiet = 1'b0;
		end
		drain_results();

		$display("Run covered %0d rank transfers over %0d register settings,", sent, settings);
		$display("%0d of them out of range or under an invalid setting.", bad_sent);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> combination_unrank.f
hdl/cu_pkg.sv
hdl/cu_binom_rom.sv
hdl/cu_search.sv
hdl/combination_unrank.sv
bench/unrank_checker.sv
bench/tb_top.sv
